FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define EVH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define EVH_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define EVH_ASSERT(lbl, prop, msg)
`define EVH_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: design/evh_pkg.sv
// Package with types, constants and reset values of the voice activity detector.
`timescale 1ns / 1ps
package evh_pkg;

   localparam int MAX_WINDOW_DEF  = 1024;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int QUEUE_DEPTH     = 2;

   localparam int ENERGY_W = 31;
   localparam int WIN_W    = 10;
   localparam int MS_W     = 16;
   localparam int DUR_W    = 24;
   localparam int HANG_W   = 17;
   localparam int FRAMES_W = 16;
   localparam int CSR_W    = 31;

   localparam logic [DUR_W-1:0]    DUR_MAX    = {DUR_W{1'b1}};
   localparam logic [HANG_W-1:0]   HANG_MAX   = {HANG_W{1'b1}};
   localparam logic [FRAMES_W-1:0] FRAMES_MAX = {FRAMES_W{1'b1}};

   localparam logic [ENERGY_W-1:0] THRESHOLD_RST = 31'd1048576;
   localparam logic [WIN_W-1:0]    WINDOW_MS_RST = 10'd20;
   localparam logic [MS_W-1:0]     MIN_SOUND_RST = 16'd100;
   localparam logic [MS_W-1:0]     POST_BUF_RST  = 16'd200;

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_WINDOW_MS = 2'd1,
      REG_MIN_SOUND = 2'd2,
      REG_POST_BUF  = 2'd3
   } evh_reg_type;

   typedef enum logic [1:0] {
      ST_SILENCE   = 2'd0,
      ST_CANDIDATE = 2'd1,
      ST_ACTIVE    = 2'd2,
      ST_HANGOVER  = 2'd3
   } evh_mode_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DIV,
      PH_STEP
   } evh_phase_type;

   typedef struct packed {
      logic              we;
      evh_reg_type       index;
      logic [CSR_W-1:0]  wdata;
   } evh_csr_type;

endpackage

FILE: design/evh_if.sv
// Stream interfaces for sample transactions and window result transactions.
`timescale 1ns / 1ps
interface evh_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          window_end;

   modport source (output valid, output sample, output window_end, input ready);
   modport sink   (input valid, input sample, input window_end, output ready);
endinterface

interface evh_rsp_if;
   import evh_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ENERGY_W-1:0]   energy;
   logic                  voice_flag;
   logic [DUR_W-1:0]      voice_duration_ms;
   logic [1:0]            detector_state;

   modport source (output valid, output energy, output voice_flag,
                   output voice_duration_ms, output detector_state, input ready);
   modport sink   (input valid, input energy, input voice_flag,
                   input voice_duration_ms, input detector_state, output ready);
endinterface

FILE: design/energy_vad_hangover_top.sv
// Top level of the energy threshold voice activity detector with hangover.
`timescale 1ns / 1ps
// Samples are taken one per cycle while a window accumulates; squaring and
// accumulation form a two-stage front end. Each closed window goes into a
// two-entry queue, and the back end loads it, runs a restoring divider that
// forms the mean energy one bit per cycle, and then steps the detector.
// Windows shorter than the back end's time per window throttle the sample
// input once the queue fills; a result waiting at the output register holds
// the back end in its step, so the next division starts only after that
// result is taken. No clearing pass follows reset.
module energy_vad_hangover_top #(
   parameter int MAX_WINDOW  = evh_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = evh_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   evh_req_if.sink                       req_chan,
   evh_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [evh_pkg::CSR_W-1:0]     csr_wdata
);
   import evh_pkg::*;

   localparam int SUM_W = $clog2(MAX_WINDOW) + ENERGY_W;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   logic [SUM_W-1:0]   push_sum;
   logic [CNT_W-1:0]   push_cnt;
   logic [SUM_W-1:0]   pop_sum;
   logic [CNT_W-1:0]   pop_cnt;
   evh_csr_type        csr;

   assign csr.we    = csr_we;
   assign csr.index = evh_reg_type'(csr_index);
   assign csr.wdata = csr_wdata;

   evh_front #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_sum  (push_sum),
      .q_cnt  (push_cnt)
   );

   evh_queue #(
      .WIDTH (SUM_W + CNT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_sum, push_cnt}),
      .pop       (q_pop),
      .pop_data  ({pop_sum, pop_cnt}),
      .full      (q_full),
      .empty     (q_empty)
   );

   evh_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .SUM_W      (SUM_W),
      .CNT_W      (CNT_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .q_empty (q_empty),
      .q_sum   (pop_sum),
      .q_cnt   (pop_cnt),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

FILE: design/evh_front.sv
// Front end: squares samples, accumulates a window and pushes closed windows.
`timescale 1ns / 1ps
module evh_front #(
   parameter int MAX_WINDOW  = evh_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = evh_pkg::SAMPLE_BITS_DEF,
   parameter int SUM_W       = $clog2(MAX_WINDOW) + evh_pkg::ENERGY_W,
   parameter int CNT_W       = $clog2(MAX_WINDOW + 1)
) (
   input  logic              clock,
   input  logic              reset,
   evh_req_if.sink           req,
   input  logic              q_full,
   output logic              q_push,
   output logic [SUM_W-1:0]  q_sum,
   output logic [CNT_W-1:0]  q_cnt
);
   import evh_pkg::*;

   localparam int SHL   = (SAMPLE_BITS < 16) ? 2 * (16 - SAMPLE_BITS) : 0;
   localparam int SHR   = (SAMPLE_BITS > 16) ? 2 * (SAMPLE_BITS - 16) : 0;
   localparam int SQX_W = 2 * SAMPLE_BITS + SHL;

   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] sq;
   logic [SQX_W-1:0]         sq_ext;

   logic                 s1_valid_ff;
   logic [ENERGY_W-1:0]  s1_sq_ff;
   logic                 s1_end_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [CNT_W-1:0]     cnt_ff;

   logic [SUM_W-1:0]     sum_in;
   logic [CNT_W-1:0]     cnt_in;
   logic                 close;
   logic                 s1_adv;
   logic                 take;

   always_comb begin
      mag    = req.sample[SAMPLE_BITS-1] ? (~req.sample + 1'b1) : req.sample;
      sq     = mag * mag;
      sq_ext = (SQX_W'(sq) << SHL) >> SHR;
   end

   assign sum_in = sum_ff + SUM_W'(s1_sq_ff);
   assign cnt_in = cnt_ff + 1'b1;
   assign close  = s1_end_ff || (cnt_in == CNT_W'(MAX_WINDOW));
   assign s1_adv = s1_valid_ff && !(close && q_full);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign take   = req.valid && req.ready;

   assign q_push = s1_adv && close;
   assign q_sum  = sum_in;
   assign q_cnt  = cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         if (take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            if (close) begin
               sum_ff <= '0;
               cnt_ff <= '0;
            end else begin
               sum_ff <= sum_in;
               cnt_ff <= cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_sq_ff  <= sq_ext[ENERGY_W-1:0];
         s1_end_ff <= req.window_end;
      end
   end

endmodule

FILE: design/evh_queue.sv
// Short flip-flop queue of closed windows between front and back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module evh_queue #(
   parameter int WIDTH = 52,
   parameter int DEPTH = evh_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [WIDTH-1:0]  push_data,
   input  logic              pop,
   output logic [WIDTH-1:0]  pop_data,
   output logic              full,
   output logic              empty
);
   import evh_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `EVH_ASSERT(a_no_push_full, push |-> !full, "window pushed into full queue")
   `EVH_ASSERT(a_no_pop_empty, pop |-> !empty, "window popped from empty queue")
   `EVH_ASSERT_RST(a_cnt_bound, reset || (cnt_ff <= CNT_W'(DEPTH)), "queue count beyond depth")

endmodule

FILE: design/evh_back.sv
// Back end: divides window energy, steps the detector and holds the result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module evh_back #(
   parameter int MAX_WINDOW = evh_pkg::MAX_WINDOW_DEF,
   parameter int SUM_W      = $clog2(MAX_WINDOW) + evh_pkg::ENERGY_W,
   parameter int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  evh_pkg::evh_csr_type  csr,
   input  logic                  q_empty,
   input  logic [SUM_W-1:0]      q_sum,
   input  logic [CNT_W-1:0]      q_cnt,
   output logic                  q_pop,
   evh_rsp_if.source             rsp
);
   import evh_pkg::*;

   localparam int ITER_W = $clog2(SUM_W);

   evh_phase_type        phase_ff, phase_in;
   logic [ITER_W-1:0]    iter_ff;
   logic [SUM_W-1:0]     num_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [CNT_W-1:0]     den_ff;

   logic [ENERGY_W-1:0]  thr_ff;
   logic [WIN_W-1:0]     win_ff;
   logic [MS_W-1:0]      min_ff;
   logic [MS_W-1:0]      post_ff;

   evh_mode_type         mode_ff, mode_in;
   logic [FRAMES_W-1:0]  cand_ff, cand_in;
   logic [HANG_W-1:0]    hang_ff, hang_in;
   logic [DUR_W-1:0]     voice_ff, voice_in;

   logic                 rsp_valid_ff;
   logic [ENERGY_W-1:0]  rsp_energy_ff;
   logic                 rsp_active_ff;
   logic [DUR_W-1:0]     rsp_dur_ff;
   logic [1:0]           rsp_state_ff;

   logic [CNT_W:0]       rem_shift;
   logic                 ge;
   logic                 out_free;
   logic                 step_go;
   logic [ENERGY_W-1:0]  energy;
   logic                 voiced;
   logic [DUR_W:0]       voice_add;
   logic [DUR_W-1:0]     voice_sat;
   logic [FRAMES_W:0]    cand_add;
   logic [FRAMES_W-1:0]  cand_sat;
   logic [FRAMES_W+WIN_W-1:0] cand_prod;
   logic [HANG_W:0]      hang_add;
   logic [HANG_W-1:0]    hang_sat;
   logic                 active;

   assign rem_shift = {rem_ff, num_ff[SUM_W-1]};
   assign ge        = rem_shift >= {1'b0, den_ff};
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign q_pop     = (phase_ff == PH_IDLE) && !q_empty;
   assign step_go   = (phase_ff == PH_STEP) && out_free;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (!q_empty) begin
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            if (iter_ff == '0) begin
               phase_in = PH_STEP;
            end
         end
         PH_STEP: begin
            if (out_free) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      energy    = num_ff[ENERGY_W-1:0];
      voiced    = energy > thr_ff;
      voice_add = {1'b0, voice_ff} + (DUR_W + 1)'(win_ff);
      voice_sat = (voice_add > {1'b0, DUR_MAX}) ? DUR_MAX : voice_add[DUR_W-1:0];
      cand_add  = {1'b0, cand_ff} + 1'b1;
      cand_sat  = (cand_add > {1'b0, FRAMES_MAX}) ? FRAMES_MAX : cand_add[FRAMES_W-1:0];
      cand_prod = (FRAMES_W + WIN_W)'(cand_sat) * (FRAMES_W + WIN_W)'(win_ff);
      hang_add  = {1'b0, hang_ff} + (HANG_W + 1)'(win_ff);
      hang_sat  = (hang_add > {1'b0, HANG_MAX}) ? HANG_MAX : hang_add[HANG_W-1:0];

      mode_in  = mode_ff;
      cand_in  = cand_ff;
      hang_in  = hang_ff;
      voice_in = (mode_ff != ST_SILENCE) ? voice_sat : voice_ff;
      unique case (mode_ff)
         ST_SILENCE: begin
            if (voiced) begin
               mode_in  = ST_CANDIDATE;
               cand_in  = FRAMES_W'(1);
               voice_in = DUR_W'(win_ff);
            end
         end
         ST_CANDIDATE: begin
            if (voiced) begin
               cand_in = cand_sat;
               if (cand_prod >= (FRAMES_W + WIN_W)'(min_ff)) begin
                  mode_in = ST_ACTIVE;
               end
            end else begin
               mode_in = ST_SILENCE;
               cand_in = '0;
            end
         end
         ST_ACTIVE: begin
            if (!voiced) begin
               mode_in = ST_HANGOVER;
               hang_in = '0;
            end
         end
         ST_HANGOVER: begin
            if (voiced) begin
               mode_in = ST_ACTIVE;
            end else begin
               hang_in = hang_sat;
               if (hang_sat >= HANG_W'(post_ff)) begin
                  mode_in = ST_SILENCE;
               end
            end
         end
         default: mode_in = ST_SILENCE;
      endcase
      active = (mode_in == ST_ACTIVE) || (mode_in == ST_HANGOVER);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         thr_ff       <= THRESHOLD_RST;
         win_ff       <= WINDOW_MS_RST;
         min_ff       <= MIN_SOUND_RST;
         post_ff      <= POST_BUF_RST;
         mode_ff      <= ST_SILENCE;
         cand_ff      <= '0;
         hang_ff      <= '0;
         voice_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (csr.we) begin
            unique case (csr.index)
               REG_THRESHOLD: thr_ff  <= csr.wdata[ENERGY_W-1:0];
               REG_WINDOW_MS: win_ff  <= csr.wdata[WIN_W-1:0];
               REG_MIN_SOUND: min_ff  <= csr.wdata[MS_W-1:0];
               REG_POST_BUF:  post_ff <= csr.wdata[MS_W-1:0];
               default: ;
            endcase
         end
         if (step_go) begin
            mode_ff  <= mode_in;
            cand_ff  <= cand_in;
            hang_ff  <= hang_in;
            voice_ff <= voice_in;
         end
         if (step_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         num_ff  <= q_sum;
         den_ff  <= q_cnt;
         rem_ff  <= '0;
         iter_ff <= ITER_W'(SUM_W - 1);
      end else if (phase_ff == PH_DIV) begin
         num_ff  <= {num_ff[SUM_W-2:0], ge};
         rem_ff  <= ge ? CNT_W'(rem_shift - {1'b0, den_ff}) : rem_shift[CNT_W-1:0];
         iter_ff <= iter_ff - 1'b1;
      end
      if (step_go) begin
         rsp_energy_ff <= energy;
         rsp_active_ff <= active;
         rsp_dur_ff    <= active ? voice_in : '0;
         rsp_state_ff  <= mode_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.energy            = rsp_energy_ff;
   assign rsp.voice_flag        = rsp_active_ff;
   assign rsp.voice_duration_ms = rsp_dur_ff;
   assign rsp.detector_state    = rsp_state_ff;

   `EVH_ASSERT(a_den_nonzero, (phase_ff == PH_DIV) |-> (den_ff != '0), "divide by empty window")

endmodule
